[hw/rtl/ffse_pkg.sv]
package ffse_pkg;

    localparam int FIELD_WIDTH_DEF  = 320;
    localparam int FIELD_HEIGHT_DEF = 200;
    localparam int BED_MARGIN_DEF   = 10;
    localparam int MATCH_SPAN_DEF   = 5;

    localparam logic [5:0] WALK_HALF   = 6'd20;
    localparam logic [7:0] COOL_FLOOR  = 8'd4;
    localparam logic [7:0] BURN_LEVEL  = 8'd50;
    localparam logic [7:0] CATCH_LEVEL = 8'd10;
    localparam logic [7:0] FULL_HEAT   = 8'd255;

    typedef enum logic [2:0] {
        REQ_MATCH  = 3'd0,
        REQ_GROW   = 3'd1,
        REQ_ZERO   = 3'd2,
        REQ_SMOOTH = 3'd3,
        REQ_SEED   = 3'd4,
        REQ_RISE   = 3'd5,
        REQ_READ   = 3'd6
    } req_code_t;

    localparam logic [0:0] REG_IGNITION = 1'd0;
    localparam logic [0:0] REG_BIAS     = 1'd1;

    typedef struct packed {
        logic [2:0] req_type;
        logic [9:0] column;
        logic [9:0] row;
        logic [6:0] ignite_draw;
        logic [5:0] walk_draw;
        logic [1:0] jitter_draw;
        logic [1:0] cool_draw;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] value;
        logic       write_skipped;
    } out_beat_t;

    // classified operation handed from front to back
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_MATCH  = 4'd1,
        OP_GROW   = 4'd2,
        OP_ZERO   = 4'd3,
        OP_SMOOTH = 4'd4,
        OP_HOLD   = 4'd5,
        OP_SEED   = 4'd6,
        OP_RISE   = 4'd7,
        OP_RCOLD  = 4'd8,
        OP_READ   = 4'd9,
        OP_SKIP   = 4'd10
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [9:0] x;
        logic [9:0] y;
        logic [6:0] ign;
        logic [5:0] walk;
        logic [1:0] jit;
        logic [1:0] cool;
    } cmd_t;

endpackage

[hw/rtl/flame_field_step_engine.sv]
// Flow: after accept, S_RD0 goes straight to S_OUT for a no-op or zero, through S_EXEC for most
// operations, through S_RD1, S_RD2 and S_EXEC for smooth, and through S_MATCH for match. The back
// end takes no new beat until S_OUT has handed the result on; its steps are set by the single read
// port of the field and bed RAMs (smooth reads three bed taps, match writes one bed column per cycle).
// Reset: asynchronous, active low; then a clearing pass zeroes field and bed while up to two beats
// queue in the front. Registers reset to 3 and 1.
module flame_field_step_engine #(
    parameter int FIELD_WIDTH  = ffse_pkg::FIELD_WIDTH_DEF,
    parameter int FIELD_HEIGHT = ffse_pkg::FIELD_HEIGHT_DEF,
    parameter int BED_MARGIN   = ffse_pkg::BED_MARGIN_DEF,
    parameter int MATCH_SPAN   = ffse_pkg::MATCH_SPAN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffse_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ffse_pkg::out_beat_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ffse_pkg::*;

    logic       q_valid;
    logic       q_ready;
    cmd_t       q_data;
    logic       busy;
    logic [6:0] ign_reg;
    logic [3:0] bias_reg;
    logic       wr;

    ffse_front #(
        .FIELD_WIDTH(FIELD_WIDTH), .FIELD_HEIGHT(FIELD_HEIGHT),
        .BED_MARGIN(BED_MARGIN), .MATCH_SPAN(MATCH_SPAN)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    ffse_back #(
        .FIELD_WIDTH(FIELD_WIDTH), .FIELD_HEIGHT(FIELD_HEIGHT), .MATCH_SPAN(MATCH_SPAN)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .ignition_rate(ign_reg), .intensity_bias(bias_reg), .busy(busy),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_comb
    begin
        prdata = 32'd0;
        case (paddr[2])
            REG_IGNITION: prdata = {25'd0, ign_reg};
            REG_BIAS:     prdata = {{28{bias_reg[3]}}, bias_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ign_reg  <= 7'd3;
            bias_reg <= 4'd1;
        end
        else if (wr && paddr[1:0] == 2'd0)
        begin
            case (paddr[2])
                REG_IGNITION: ign_reg <= pwdata[6:0];
                REG_BIAS:     bias_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat dropped while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("pending result not counted as busy");

endmodule

[hw/rtl/ffse_ram.sv]
module ffse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/ffse_front.sv]
module ffse_front #(
    parameter int FIELD_WIDTH  = ffse_pkg::FIELD_WIDTH_DEF,
    parameter int FIELD_HEIGHT = ffse_pkg::FIELD_HEIGHT_DEF,
    parameter int BED_MARGIN   = ffse_pkg::BED_MARGIN_DEF,
    parameter int MATCH_SPAN   = ffse_pkg::MATCH_SPAN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ffse_pkg::in_beat_t in_data,
    output logic               q_valid,
    input  logic               q_ready,
    output ffse_pkg::cmd_t     q_data
);
    import ffse_pkg::*;

    localparam int QD = 2;
    localparam logic [10:0] BED_LO = 11'(BED_MARGIN);
    localparam logic [10:0] BED_HI = 11'(FIELD_WIDTH - BED_MARGIN);
    localparam logic [10:0] MS_HI  = 11'(FIELD_WIDTH - BED_MARGIN - MATCH_SPAN);
    localparam logic [10:0] FW     = 11'(FIELD_WIDTH);
    localparam logic [10:0] FH     = 11'(FIELD_HEIGHT);

    cmd_t       q_reg [QD];
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    cmd_t       cmd;
    logic [10:0] x;
    logic [10:0] y;
    logic       in_bed;
    logic       push;
    logic       pop;

    assign x = {1'b0, in_data.column};
    assign y = {1'b0, in_data.row};
    assign in_bed = (x >= BED_LO) && (x < BED_HI);

    always_comb
    begin
        cmd.x = in_data.column;
        cmd.y = in_data.row;
        cmd.ign = in_data.ignite_draw;
        cmd.walk = (in_data.walk_draw > 6'd40) ? 6'd40 : in_data.walk_draw;
        cmd.jit = (in_data.jitter_draw > 2'd2) ? 2'd2 : in_data.jitter_draw;
        cmd.cool = in_data.cool_draw;
        cmd.op = OP_NONE;
        case (req_code_t'(in_data.req_type))
            REQ_MATCH:
            begin
                cmd.op = OP_MATCH;
                if (x > MS_HI)
                begin
                    cmd.x = MS_HI[9:0];
                end
                else if (x < BED_LO)
                begin
                    cmd.x = BED_LO[9:0];
                end
            end
            REQ_GROW:   cmd.op = in_bed ? OP_GROW : OP_NONE;
            REQ_ZERO:   cmd.op = in_bed ? OP_ZERO : OP_NONE;
            REQ_SMOOTH:
            begin
                if (in_bed)
                begin
                    cmd.op = ((x - 11'd1 >= BED_LO) && (x + 11'd1 < BED_HI)) ?
                             OP_SMOOTH : OP_HOLD;
                end
            end
            REQ_SEED:   cmd.op = in_bed ? OP_SEED : OP_NONE;
            REQ_RISE:   cmd.op = (x < FW && y >= 11'd1 && y < FH) ? OP_RISE : OP_SKIP;
            REQ_READ:   cmd.op = (x < FW && y < FH) ? OP_READ : OP_NONE;
            default:    cmd.op = OP_NONE;
        endcase
    end

    assign in_ready = (cnt_reg != 2'(QD));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = q_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[hw/rtl/ffse_back.sv]
module ffse_back #(
    parameter int FIELD_WIDTH  = ffse_pkg::FIELD_WIDTH_DEF,
    parameter int FIELD_HEIGHT = ffse_pkg::FIELD_HEIGHT_DEF,
    parameter int MATCH_SPAN   = ffse_pkg::MATCH_SPAN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  ffse_pkg::cmd_t      q_data,
    input  logic [6:0]          ignition_rate,
    input  logic [3:0]          intensity_bias,
    output logic                busy,
    output logic                out_valid,
    input  logic                out_ready,
    output ffse_pkg::out_beat_t out_data
);
    import ffse_pkg::*;

    localparam int FDEPTH = FIELD_WIDTH * FIELD_HEIGHT;
    localparam int FAW = $clog2(FDEPTH);
    localparam int BAW = $clog2(FIELD_WIDTH);
    localparam int MSW = $clog2(MATCH_SPAN + 1);
    localparam logic [10:0] FW = 11'(FIELD_WIDTH);
    localparam logic [FAW-1:0] LAST_ROW = FAW'((FIELD_HEIGHT - 1) * FIELD_WIDTH);
    localparam logic [FAW:0] FDEPTH_C = (FAW+1)'(FDEPTH);
    localparam logic [BAW:0] BDEPTH_C = (BAW+1)'(FIELD_WIDTH);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_RD0   = 8'b00000100,
        S_RD1   = 8'b00001000,
        S_RD2   = 8'b00010000,
        S_EXEC  = 8'b00100000,
        S_MATCH = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    cmd_t           cmd_reg;
    logic [FAW:0]   clr_reg;
    logic [MSW-1:0] k_reg;
    logic [7:0]     t0_reg;
    logic [7:0]     t1_reg;
    logic [7:0]     val_reg;
    logic           skip_reg;
    logic [7:0]     res_val_reg;
    logic           res_skip_reg;
    logic           ovalid_reg;
    logic [FAW-1:0] rowbase_reg;

    logic           f_we;
    logic [FAW-1:0] f_waddr;
    logic [7:0]     f_wdata;
    logic [FAW-1:0] f_raddr;
    logic [7:0]     f_rdata;
    logic           b_we;
    logic [BAW-1:0] b_waddr;
    logic [7:0]     b_wdata;
    logic [BAW-1:0] b_raddr;
    logic [7:0]     b_rdata;

    logic [9:0]     sum;
    logic [7:0]     avg;
    logic [6:0]     top;
    logic [6:0]     ign_s;
    logic signed [10:0] grow_h;
    logic [7:0]     grow_v;
    logic [7:0]     rise_v;
    logic [10:0]    dest;
    logic [10:0]    xm;

    ffse_ram #(.WIDTH(8), .DEPTH(FDEPTH)) u_field (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    ffse_ram #(.WIDTH(8), .DEPTH(FIELD_WIDTH)) u_bed (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    // cmd.y * FIELD_WIDTH, registered once per item
    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            rowbase_reg <= FAW'(32'(q_data.y) * FIELD_WIDTH);
        end
    end

    assign xm     = {1'b0, cmd_reg.x} - 11'd1;
    assign sum    = {2'b0, t0_reg} + {2'b0, t1_reg} + {2'b0, b_rdata};
    assign avg    = 8'((20'(sum) * 20'd683) >> 11);
    assign top    = (ignition_rate == 7'd0) ? 7'd0 : ignition_rate - 7'd1;
    assign ign_s  = (cmd_reg.ign > top) ? top : cmd_reg.ign;
    assign rise_v = f_rdata - {6'd0, cmd_reg.cool};
    assign dest   = {1'b0, cmd_reg.x} + {9'd0, cmd_reg.jit} - 11'd1;

    always_comb
    begin
        grow_h = {3'b0, b_rdata};
        if (b_rdata < BURN_LEVEL)
        begin
            if (b_rdata > CATCH_LEVEL)
            begin
                grow_h = grow_h + 11'(signed'({1'b0, ign_s}));
            end
        end
        else
        begin
            grow_h = grow_h + 11'(signed'({1'b0, cmd_reg.walk}))
                     - 11'(signed'({1'b0, WALK_HALF}))
                     + 11'(signed'(intensity_bias));
        end
        if (grow_h < 0)
        begin
            grow_v = 8'd0;
        end
        else if (grow_h > 11'sd255)
        begin
            grow_v = FULL_HEAT;
        end
        else
        begin
            grow_v = grow_h[7:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        f_we = 1'b0;
        f_waddr = LAST_ROW + FAW'(cmd_reg.x);
        f_wdata = 8'd0;
        f_raddr = rowbase_reg + FAW'(cmd_reg.x);
        b_we = 1'b0;
        b_waddr = BAW'(cmd_reg.x);
        b_wdata = 8'd0;
        b_raddr = BAW'(cmd_reg.x);
        case (state_reg)
            S_CLEAR:
            begin
                f_we = (clr_reg < FDEPTH_C);
                f_waddr = clr_reg[FAW-1:0];
                b_we = ((FAW+1)'(clr_reg) < (FAW+1)'(BDEPTH_C));
                b_waddr = clr_reg[BAW-1:0];
                if (clr_reg == FDEPTH_C || (clr_reg + 1'b1) > FDEPTH_C)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                case (cmd_reg.op)
                    OP_MATCH: state_next = S_MATCH;
                    OP_ZERO:
                    begin
                        b_we = 1'b1;
                        state_next = S_OUT;
                    end
                    OP_SMOOTH:
                    begin
                        b_raddr = BAW'(xm);
                        state_next = S_RD1;
                    end
                    OP_NONE, OP_SKIP: state_next = S_OUT;
                    default: state_next = S_EXEC;
                endcase
            end
            S_RD1:
            begin
                b_raddr = BAW'(cmd_reg.x + 10'd1);
                state_next = S_RD2;
            end
            S_RD2:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                case (cmd_reg.op)
                    OP_GROW:
                    begin
                        b_we = 1'b1;
                        b_wdata = grow_v;
                    end
                    OP_SMOOTH:
                    begin
                        b_we = 1'b1;
                        b_wdata = avg;
                    end
                    OP_SEED:
                    begin
                        f_we = 1'b1;
                        f_wdata = b_rdata;
                    end
                    OP_RISE:
                    begin
                        f_wdata = (f_rdata < COOL_FLOOR) ? 8'd0 : rise_v;
                        f_we = (f_rdata < COOL_FLOOR) || (dest < FW);
                        f_waddr = rowbase_reg - FAW'(FIELD_WIDTH) +
                                  ((f_rdata < COOL_FLOOR) ? FAW'(cmd_reg.x) : FAW'(dest));
                    end
                    default: ;
                endcase
            end
            S_MATCH:
            begin
                b_we = 1'b1;
                b_waddr = BAW'(cmd_reg.x + 10'(k_reg));
                b_wdata = FULL_HEAT;
                if (k_reg == MSW'(MATCH_SPAN - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign q_ready = (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE) || ovalid_reg || q_valid;
    assign out_valid = ovalid_reg;
    assign out_data.value = res_val_reg;
    assign out_data.write_skipped = res_skip_reg;

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            cmd_reg <= q_data;
        end
        if (state_reg == S_RD1)
        begin
            t0_reg <= b_rdata;
        end
        if (state_reg == S_RD2)
        begin
            t1_reg <= b_rdata;
        end
        if (state_reg == S_RD0)
        begin
            val_reg <= (cmd_reg.op == OP_MATCH) ? FULL_HEAT : 8'd0;
            skip_reg <= (cmd_reg.op == OP_SKIP);
        end
        if (state_reg == S_EXEC)
        begin
            case (cmd_reg.op)
                OP_GROW:   val_reg <= grow_v;
                OP_SMOOTH: val_reg <= avg;
                OP_HOLD:   val_reg <= b_rdata;
                OP_SEED:   val_reg <= b_rdata;
                OP_READ:   val_reg <= f_rdata;
                OP_RISE:
                begin
                    val_reg <= (f_rdata < COOL_FLOOR) ? 8'd0 : rise_v;
                    skip_reg <= (f_rdata >= COOL_FLOOR) && (dest >= FW);
                end
                default: ;
            endcase
        end
        if (state_reg == S_OUT && (!ovalid_reg || out_ready))
        begin
            res_val_reg  <= val_reg;
            res_skip_reg <= skip_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            k_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == S_MATCH)
            begin
                k_reg <= k_reg + 1'b1;
            end
            else
            begin
                k_reg <= '0;
            end
            if (out_valid && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (state_reg == S_OUT && (!ovalid_reg || out_ready))
            begin
                ovalid_reg <= 1'b1;
            end
        end
    end

endmodule
